>>> rtl/csmv_pkg.sv
package csmv_pkg;

  // Store depth and the address width that follows from it.
  localparam int MAX_ELEMS = 1024;
  localparam int ADDR_W    = $clog2(MAX_ELEMS);

  // Field widths of the item and result.
  localparam int IDX_W     = 10;
  localparam int VAL_W     = 32;
  localparam int CNT_W     = 11;
  localparam int SIZE_W    = (CNT_W > ADDR_W + 1) ? CNT_W : ADDR_W + 1;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int FRAC_W    = 16;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_APPLY = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_ROW_COUNT = 2'd0,
    REG_COL_COUNT = 2'd1,
    REG_TRANSPOSE = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DONE
  } state_t;

endpackage

>>> rtl/coo_sparse_matvec.sv
// Coordinate-list sparse matrix times vector in Q16.16 fixed point. Each input
// item carries a command in in_tuser: load one element of the input vector,
// apply one nonzero (y[row] += coef*x[col], or y[col] += coef*x[row] when the
// transpose register is set), or read one output element and clear it. Every
// item produces exactly one result item with a status bit in out_tuser (1 when
// an index is outside the configured space or the command is unused, in which
// case nothing changes) and the read value in out_tdata (zero except for a
// successful read). The vector and the accumulator each live in one
// synchronous RAM of MAX_ELEMS words. An item is accepted while both RAMs
// are addressed, the read data is multiplied in the READ state, and the
// rounded, saturated sum is written back and loaded into the output register
// in the DONE state; only then does the block accept the next item, so items
// never overlap in the RAM read-modify-write sequence. A result that has not
// been taken holds the write-back stage until it drains. After reset the
// accumulator RAM is cleared one word per cycle with in_tready low;
// configuration writes are taken during that pass. The vector RAM is not
// cleared, so every vector element must be loaded before a nonzero uses it.
module coo_sparse_matvec
  import csmv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input items.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // in_tdata, lowest bit first: row_index[9:0], col_index[19:10],
  // value[51:20], zero fill[55:52].
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: cmd[1:0].
  input  logic [1:0]            in_tuser,
  // Result items.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_tdata: read_value[31:0].
  output logic [OUT_DATA_W-1:0] out_tdata,
  // out_tuser: status[0].
  output logic                  out_tuser,
  // Configuration registers.
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // Configuration registers.
  logic [CNT_W-1:0] row_count_r;
  logic [CNT_W-1:0] col_count_r;
  logic             transpose_r;
  reg_idx_t         cfg_idx;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= CNT_W'(1024);
      col_count_r <= CNT_W'(1024);
      transpose_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ROW_COUNT: row_count_r <= cfg_pwdata[CNT_W-1:0];
        REG_COL_COUNT: col_count_r <= cfg_pwdata[CNT_W-1:0];
        REG_TRANSPOSE: transpose_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (cfg_idx)
      REG_ROW_COUNT: cfg_prdata = CFG_DATA_W'(row_count_r);
      REG_COL_COUNT: cfg_prdata = CFG_DATA_W'(col_count_r);
      REG_TRANSPOSE: cfg_prdata = CFG_DATA_W'(transpose_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // Sizes of the spaces in use, limited to the store depth.
  logic [SIZE_W-1:0] rows;
  logic [SIZE_W-1:0] cols;
  logic [SIZE_W-1:0] in_size;
  logic [SIZE_W-1:0] out_size;

  assign rows     = (SIZE_W'(row_count_r) > SIZE_W'(MAX_ELEMS)) ? SIZE_W'(MAX_ELEMS)
                                                                : SIZE_W'(row_count_r);
  assign cols     = (SIZE_W'(col_count_r) > SIZE_W'(MAX_ELEMS)) ? SIZE_W'(MAX_ELEMS)
                                                                : SIZE_W'(col_count_r);
  assign in_size  = transpose_r ? rows : cols;
  assign out_size = transpose_r ? cols : rows;

  // Unpack the incoming item and check its indices.
  cmd_t                    in_cmd;
  logic [IDX_W-1:0]        in_row;
  logic [IDX_W-1:0]        in_col;
  logic signed [VAL_W-1:0] in_value;
  logic                    in_ok;
  logic [ADDR_W-1:0]       vec_raddr;
  logic [ADDR_W-1:0]       acc_addr;

  assign in_cmd   = cmd_t'(in_tuser);
  assign in_row   = in_tdata[9:0];
  assign in_col   = in_tdata[19:10];
  assign in_value = in_tdata[51:20];

  always_comb begin
    case (in_cmd)
      CMD_LOAD:  in_ok = SIZE_W'(in_row) < in_size;
      CMD_APPLY: in_ok = (SIZE_W'(in_row) < rows) && (SIZE_W'(in_col) < cols);
      CMD_READ:  in_ok = SIZE_W'(in_row) < out_size;
      default:   in_ok = 1'b0;
    endcase
  end

  // The source element comes from the input space, the destination from the
  // output space; a read addresses the accumulator by row_index directly.
  assign vec_raddr = transpose_r ? ADDR_W'(in_row) : ADDR_W'(in_col);
  assign acc_addr  = (in_cmd == CMD_APPLY && transpose_r) ? ADDR_W'(in_col)
                                                          : ADDR_W'(in_row);

  // Item registers, loaded when the item is accepted.
  cmd_t                     cmd_r;
  logic                     ok_r;
  logic [ADDR_W-1:0]        addr_r;
  logic signed [VAL_W-1:0]  value_r;
  logic signed [PROD_W-1:0] prod_r;

  state_t state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              accept;
  logic              out_load;

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_cmd;
      ok_r    <= in_ok;
      addr_r  <= acc_addr;
      value_r <= in_value;
    end
  end

  // Vector RAM: written by a load, read when an item is accepted.
  logic signed [VAL_W-1:0] vec_mem [MAX_ELEMS];
  logic signed [VAL_W-1:0] vec_q_r;
  logic                    vec_we;

  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec_mem[addr_r] <= value_r;
    end
    if (accept) begin
      vec_q_r <= vec_mem[vec_raddr];
    end
  end

  // Accumulator RAM: one write port shared by the clearing pass and the
  // write-back stage, one read port used on acceptance.
  logic signed [VAL_W-1:0] acc_mem [MAX_ELEMS];
  logic signed [VAL_W-1:0] acc_q_r;
  logic                    acc_we;
  logic [ADDR_W-1:0]       acc_waddr;
  logic signed [VAL_W-1:0] acc_wdata;

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    if (accept) begin
      acc_q_r <= acc_mem[acc_addr];
    end
  end

  // The signed 32x32 product is registered before rounding and summing.
  always_ff @(posedge clk) begin
    if (state_r == ST_READ) begin
      prod_r <= PROD_W'(value_r) * PROD_W'(vec_q_r);
    end
  end

  // Round to nearest with ties toward plus infinity, then saturate the sum.
  logic signed [PROD_W-1:0]         prod_rnd;
  logic signed [PROD_W-FRAC_W-1:0]  prod_q;
  logic signed [PROD_W-FRAC_W:0]    acc_sum;
  logic signed [VAL_W-1:0]          acc_sat;

  assign prod_rnd = prod_r + PROD_W'(32768);
  assign prod_q   = prod_rnd[PROD_W-1:FRAC_W];
  assign acc_sum  = (PROD_W-FRAC_W+1)'(acc_q_r) + (PROD_W-FRAC_W+1)'(prod_q);

  always_comb begin
    if (acc_sum > (PROD_W-FRAC_W+1)'(32'sh7FFF_FFFF)) begin
      acc_sat = 32'sh7FFF_FFFF;
    end else if (acc_sum < (PROD_W-FRAC_W+1)'(32'sh8000_0000)) begin
      acc_sat = 32'sh8000_0000;
    end else begin
      acc_sat = acc_sum[VAL_W-1:0];
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    in_tready   = 1'b0;
    acc_we      = 1'b0;
    acc_waddr   = addr_r;
    acc_wdata   = acc_sat;
    vec_we      = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        acc_we      = 1'b1;
        acc_waddr   = clr_cnt_r;
        acc_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(MAX_ELEMS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Commit only when the output register can take the result.
        if (!out_tvalid || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
          if (ok_r) begin
            case (cmd_r)
              CMD_LOAD:  vec_we = 1'b1;
              CMD_APPLY: acc_we = 1'b1;
              CMD_READ: begin
                acc_we    = 1'b1;
                acc_wdata = '0;
              end
              default: ;
            endcase
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register.
  logic                  out_valid_r;
  logic                  out_status_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= !ok_r;
      out_data_r   <= (ok_r && cmd_r == CMD_READ) ? OUT_DATA_W'(acc_q_r) : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

>>> rtl/csmv_chk.sv
module csmv_chk
  import csmv_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser,
  input logic                  cfg_pready
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A rejected item reports a zero read value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("error result carries data");

  // The accumulator clearing pass holds off input right after reset.
  a_clear_pass: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_tready)
    else $error("input taken during clearing pass");

  // One item at a time: an accepted item blocks the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted back to back");

  a_cfg_ready: assert property (@(posedge clk) cfg_pready)
    else $error("configuration port not ready");

endmodule

bind coo_sparse_matvec csmv_chk u_csmv_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_pready (cfg_pready)
);

>>> bench/tb.sv
module tb
  import csmv_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // One command as it travels on the input stream.
  typedef struct packed {
    cmd_t             cmd;
    logic [IDX_W-1:0] row_idx;
    logic [IDX_W-1:0] col_idx;
    logic [VAL_W-1:0] value;
  } mv_cmd_t;

  // One result: the status bit from out_tuser and the word from out_tdata.
  typedef struct packed {
    logic             status;
    logic [VAL_W-1:0] read_value;
  } mv_result_t;

  localparam longint SAT_HI  = 64'sd2147483647;
  localparam longint SAT_LO  = -64'sd2147483648;
  // Number of accepted items after which the receiver holds off once.
  localparam int     HOLD_AT = 700;
  // Length of that hold-off in cycles; long enough for the block to back up.
  localparam int     HOLD_LEN = 400;
  // Commands that are in range needed per random phase before it ends.
  localparam int     PHASE_GOOD = 150;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // in_tdata, lowest bit first: row_index[9:0], col_index[19:10],
  // value[51:20], zero fill[55:52].
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // in_tuser: cmd[1:0].
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // out_tdata: read_value[31:0].
  logic [OUT_DATA_W-1:0] out_tdata;
  // out_tuser: status[0].
  logic                  out_tuser;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  coo_sparse_matvec dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // The bench keeps its own copy of the registers. They only change while
  // the block is idle, so the generator and the predictor can share them.
  logic [CNT_W-1:0]        row_cnt = 11'd1024;
  logic [CNT_W-1:0]        col_cnt = 11'd1024;
  logic                    transp = 1'b0;

  // Predicted contents of the vector RAM and of the accumulator RAM.
  logic signed [VAL_W-1:0] vec_mem [MAX_ELEMS];
  logic signed [VAL_W-1:0] acc_mem [MAX_ELEMS];
  // Which vector elements the generator has loaded so far. A nonzero is
  // never sent against an element that was not loaded, since the vector RAM
  // holds garbage until then.
  bit                      vec_loaded [MAX_ELEMS];

  mv_cmd_t                 pending_cmds [$];
  mv_result_t              awaited_results [$];
  mv_cmd_t                 offered;
  int                      accepted_cnt = 0;
  int                      good_cnt;
  int                      mismatches = 0;
  bit                      steady = 1'b0;
  int                      hold_left = 0;
  bit                      hold_armed = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  // Generous limit; a correct run needs a small fraction of it.
  initial begin
    #2_000_000;
    $display("ERROR: timeout with %0d results still awaited", awaited_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(string msg);
    if (mismatches < 200) $display("ERROR %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int space_of(int reg_val);
    return (reg_val > MAX_ELEMS) ? MAX_ELEMS : reg_val;
  endfunction

  // Executes one command on the predicted state and returns the result the
  // block must answer with. Products are exact 64-bit Q32.32 values, rounded
  // to nearest with ties going up, and the accumulation saturates.
  function automatic mv_result_t run_command(mv_cmd_t it);
    int                  rows, cols, in_sz, out_sz, src, dst;
    logic signed [63:0]  coef, x, prod;
    longint              q, sum;
    mv_result_t          res;
    rows   = space_of(row_cnt);
    cols   = space_of(col_cnt);
    in_sz  = transp ? rows : cols;
    out_sz = transp ? cols : rows;
    res.status     = 1'b1;
    res.read_value = '0;
    case (it.cmd)
      CMD_LOAD: begin
        if (it.row_idx < in_sz) begin
          vec_mem[it.row_idx] = it.value;
          res.status = 1'b0;
        end
      end
      CMD_APPLY: begin
        if (it.row_idx < rows && it.col_idx < cols) begin
          src  = transp ? it.row_idx : it.col_idx;
          dst  = transp ? it.col_idx : it.row_idx;
          coef = {{32{it.value[VAL_W-1]}}, it.value};
          x    = {{32{vec_mem[src][VAL_W-1]}}, vec_mem[src]};
          prod = coef * x;
          q    = (prod + 64'sd32768) >>> 16;
          sum  = longint'(acc_mem[dst]) + q;
          if (sum > SAT_HI) begin
            sum = SAT_HI;
          end else if (sum < SAT_LO) begin
            sum = SAT_LO;
          end
          acc_mem[dst] = sum[31:0];
          res.status = 1'b0;
        end
      end
      CMD_READ: begin
        if (it.row_idx < out_sz) begin
          res.read_value = acc_mem[it.row_idx];
          acc_mem[it.row_idx] = '0;
          res.status = 1'b0;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Mix of corner values, full-range words and small magnitudes. Small
  // values keep sums away from saturation so that rounding shows.
  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] corner [8];
    corner = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001,
               32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000};
    case ($urandom_range(9))
      0, 1:    return corner[$urandom_range(7)];
      2, 3, 4: return $urandom();
      default: return VAL_W'($urandom_range(32'h8_0000) - 32'h4_0000);
    endcase
  endfunction

  function automatic int pick_count();
    case ($urandom_range(5))
      0:       return MAX_ELEMS;
      1:       return $urandom_range(16, 1);
      2:       return $urandom_range(MAX_ELEMS, 1);
      3:       return $urandom_range(2047, MAX_ELEMS + 1);
      default: return $urandom_range(300, 17);
    endcase
  endfunction

  // An index outside a space, where the 10-bit field can reach one.
  function automatic int beyond(int size);
    return (size < MAX_ELEMS) ? $urandom_range(MAX_ELEMS - 1, size) : $urandom_range(1023);
  endfunction

  // Queues one command. A nonzero that would read a vector element never
  // loaded gets a load of that element queued in front of it.
  task automatic push_cmd(cmd_t cmd, int r, int c, logic [VAL_W-1:0] v);
    mv_cmd_t it;
    int      rows, cols, in_sz, out_sz, src;
    bit      in_range;
    rows   = space_of(row_cnt);
    cols   = space_of(col_cnt);
    in_sz  = transp ? rows : cols;
    out_sz = transp ? cols : rows;
    in_range = 1'b0;
    case (cmd)
      CMD_LOAD: begin
        in_range = r < in_sz;
        if (in_range) vec_loaded[r] = 1'b1;
      end
      CMD_APPLY: begin
        in_range = r < rows && c < cols;
        src = transp ? r : c;
        if (in_range && !vec_loaded[src]) push_cmd(CMD_LOAD, src, $urandom_range(1023), pick_value());
      end
      CMD_READ:  in_range = r < out_sz;
      default:   in_range = 1'b0;
    endcase
    if (in_range) good_cnt++;
    it.cmd     = cmd;
    it.row_idx = r[IDX_W-1:0];
    it.col_idx = c[IDX_W-1:0];
    it.value   = v;
    pending_cmds.push_back(it);
  endtask

  // One register access: a setup cycle, then an access cycle that completes
  // at the edge where pready is seen high.
  task automatic cfg_access(bit wr, reg_idx_t idx, logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (wr) begin
      case (idx)
        REG_ROW_COUNT: row_cnt = wdata[CNT_W-1:0];
        REG_COL_COUNT: col_cnt = wdata[CNT_W-1:0];
        REG_TRANSPOSE: transp  = wdata[0];
        default: begin
        end
      endcase
    end
  endtask

  // Writes all three registers with junk in the unused upper bits, pokes the
  // unused address, and reads the registers back.
  task automatic set_config(int rows, int cols, int t);
    logic [CFG_DATA_W-1:0] rd, want;
    cfg_access(1'b1, REG_ROW_COUNT, {21'($urandom()), 11'(rows)}, rd);
    cfg_access(1'b1, REG_COL_COUNT, {21'($urandom()), 11'(cols)}, rd);
    cfg_access(1'b1, REG_TRANSPOSE, {31'($urandom()), 1'(t)}, rd);
    cfg_access(1'b1, REG_UNUSED, $urandom(), rd);
    for (int i = 0; i < 3; i++) begin
      cfg_access(1'b0, reg_idx_t'(i), '0, rd);
      want = (i == 0) ? 32'(row_cnt) : (i == 1) ? 32'(col_cnt) : 32'(transp);
      if (rd !== want) report_mismatch($sformatf("register %0d reads %h, want %h", i, rd, want));
    end
  endtask

  // Blocks until every queued command went in and every result came out.
  // The check is made on the falling edge, after the driver and the monitor
  // have settled, so an item offered at the last rising edge is not missed.
  task automatic drain();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_tvalid || awaited_results.size() != 0);
  endtask

  // Input driver. The prediction is made at the edge where an item is taken,
  // using the registers as they stand then. A new item is offered only when
  // the current one is gone; it idles with a chance of 9 in 100 unless steady.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        awaited_results.push_back(run_command(offered));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_cmds.size() != 0 && (steady || $urandom_range(99) >= 9)) begin
          offered = pending_cmds.pop_front();
          in_tdata  <= {4'b0, offered.value, offered.col_idx, offered.row_idx};
          in_tuser  <= offered.cmd;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // One long hold-off on the result side, counted here. It starts once,
  // partway through the random part, while the driver keeps offering items,
  // so the block backs up and drops in_tready.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && accepted_cnt >= HOLD_AT) begin
      hold_left  <= HOLD_LEN;
      hold_armed <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor. Every taken result is matched against the oldest
  // prediction, field by field.
  always @(posedge clk) begin
    mv_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result status %b value %h with none awaited",
                                    out_tuser, out_tdata));
        end else begin
          want = awaited_results.pop_front();
          if (out_tuser !== want.status)
            report_mismatch($sformatf("status %b, want %b", out_tuser, want.status));
          if (out_tdata !== want.read_value)
            report_mismatch($sformatf("read value %h, want %h", out_tdata, want.read_value));
        end
      end
      out_tready <= (hold_left == 0) && (steady || $urandom_range(99) >= 9);
    end
  end

  initial begin
    int rows, cols, in_sz, out_sz, span, rb, cb, ib, ob, r, c;
    for (int i = 0; i < MAX_ELEMS; i++) acc_mem[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Full-size spaces. The accumulator is still being cleared after reset;
    // register writes are taken during that pass and items simply wait.
    set_config(MAX_ELEMS, MAX_ELEMS, 0);
    // Saturation in both directions, with two nonzeros on the same row back
    // to back so the second adds to the sum written back by the first.
    push_cmd(CMD_LOAD, 0, 0, 32'h7FFF_FFFF);
    push_cmd(CMD_LOAD, 1023, 1023, 32'h8000_0000);
    push_cmd(CMD_LOAD, 1, 0, 32'h0000_8000);
    push_cmd(CMD_APPLY, 0, 0, 32'h7FFF_FFFF);
    push_cmd(CMD_APPLY, 0, 0, 32'h7FFF_FFFF);
    push_cmd(CMD_READ, 0, 0, '0);
    push_cmd(CMD_APPLY, 1023, 1023, 32'h7FFF_FFFF);
    push_cmd(CMD_READ, 1023, 1023, 32'hFFFF_FFFF);
    // Rounding ties: +half rounds up to one step, -half rounds up to zero.
    push_cmd(CMD_APPLY, 5, 1, 32'h0000_0001);
    push_cmd(CMD_APPLY, 6, 1, 32'hFFFF_FFFF);
    push_cmd(CMD_READ, 5, 0, '0);
    push_cmd(CMD_READ, 6, 0, '0);
    // The unused command, with every field bit set.
    push_cmd(CMD_NONE, 1023, 1023, 32'hFFFF_FFFF);
    // A second read sees the element cleared by the first.
    push_cmd(CMD_READ, 5, 0, '0);
    drain();

    // A row space of size zero under transpose: no load and no nonzero can
    // land, while reads of the column space still work. The oversized column
    // count is limited to the store depth.
    set_config(0, 2047, 1);
    push_cmd(CMD_LOAD, 0, 0, 32'h0001_0000);
    push_cmd(CMD_APPLY, 0, 0, 32'h0001_0000);
    push_cmd(CMD_READ, 1023, 0, '0);
    push_cmd(CMD_READ, 0, 0, '0);
    drain();

    // Spaces of size one: index zero passes, index one is rejected.
    set_config(1, 1, 0);
    push_cmd(CMD_LOAD, 1, 0, 32'h0002_0000);
    push_cmd(CMD_LOAD, 0, 0, 32'h0002_0000);
    push_cmd(CMD_APPLY, 0, 1, 32'h0001_0000);
    push_cmd(CMD_APPLY, 1, 0, 32'h0001_0000);
    push_cmd(CMD_APPLY, 0, 0, 32'hFFFE_8000);
    push_cmd(CMD_READ, 1, 0, '0);
    push_cmd(CMD_READ, 0, 0, '0);
    drain();

    // Random phases. Most traffic is small products: load part of the vector,
    // apply nonzeros inside a narrow window so rows repeat often, then read
    // out and clear the touched outputs. Occasional bursts of random commands
    // and out-of-range indices are mixed in. Phase two runs without idling.
    for (int ph = 0; ph < 8; ph++) begin
      set_config(pick_count(), pick_count(), $urandom_range(1));
      steady   = (ph == 2);
      good_cnt = 0;
      rows   = space_of(row_cnt);
      cols   = space_of(col_cnt);
      in_sz  = transp ? rows : cols;
      out_sz = transp ? cols : rows;
      while (good_cnt < PHASE_GOOD) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(4, 1))
            push_cmd(cmd_t'($urandom_range(3)), $urandom_range(1023), $urandom_range(1023),
                     pick_value());
        end else begin
          span = ($urandom_range(3) == 0) ? $urandom_range(48, 1) : $urandom_range(5, 1);
          rb = $urandom_range(rows - 1);
          cb = $urandom_range(cols - 1);
          ib = transp ? rb : cb;
          ob = transp ? cb : rb;
          repeat ($urandom_range(span, 1))
            push_cmd(CMD_LOAD, (ib + $urandom_range(span - 1)) % in_sz, $urandom_range(1023),
                     pick_value());
          repeat ($urandom_range(2 * span, 1)) begin
            r = (rb + $urandom_range(span - 1)) % rows;
            c = (cb + $urandom_range(span - 1)) % cols;
            if ($urandom_range(15) == 0) begin
              if ($urandom_range(1)) r = beyond(rows);
              else c = beyond(cols);
            end
            push_cmd(CMD_APPLY, r, c, pick_value());
          end
          for (int k = 0; k < span; k++)
            push_cmd(CMD_READ, (ob + k) % out_sz, $urandom_range(1023), $urandom());
        end
      end
      drain();
    end
    steady = 1'b0;

    // Let any stray result show up before deciding.
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
